// ===== hw/rtl/rhc_pkg.sv =====
`default_nettype none

package rhc_pkg;

  // Channel and result widths
  localparam int unsigned ChanW = 8;
  localparam int unsigned HueW  = 15;
  localparam int unsigned QuoW  = 12;

  // Number of division cells: one quotient bit per cell
  localparam int unsigned NumCells = QuoW;

  // Hue scale: one sixth of a turn and a full turn in 1/64-degree units
  localparam logic [HueW-1:0] HueSixth  = HueW'(3840);
  localparam logic [HueW-1:0] HueTurn   = HueW'(23040);
  localparam logic [HueW-1:0] HueGreen  = HueW'(7680);
  localparam logic [HueW-1:0] HueBlue   = HueW'(15360);

  // Dividend multipliers
  localparam int unsigned HueDivW = ChanW + QuoW;
  localparam logic [QuoW-1:0] HueMul = QuoW'(3840);
  localparam logic [ChanW-1:0] SatMul = ChanW'(255);

  // One restoring-division lane: partial remainder, divisor and the
  // combined dividend/quotient shift word
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [ChanW-1:0] dvs;
    logic [QuoW-1:0]  nq;
  } rhc_lane_t;

  // Data that rides along the cell row
  typedef struct packed {
    rhc_lane_t        hue_lane;
    rhc_lane_t        sat_lane;
    logic [HueW-1:0]  base;
    logic             red_max;
    logic             neg;
    logic             grey;
    logic [ChanW-1:0] val;
  } rhc_cell_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rgb_to_hsv_converter_unit.sv =====
// Path: an accepted pixel passes the front register, twelve division cells
// and the output register before its result reaches the master side.
// Throughput: one pixel per cycle unless the master side stalls; each cell resolves
// one quotient bit of both the hue and the saturation division and passes the pixel on.
// Reset: rst_ni clears all valid flags asynchronously; no pixel is in flight
// and the block is ready for input right after reset.
`default_nettype none

module rgb_to_hsv_converter_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  wire  [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // hue [14:0], saturation [22:15], brightness_value [30:23], zero [31]
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned N = rhc_pkg::NumCells;

  logic               front_valid, front_ready;
  rhc_pkg::rhc_cell_t front_data;

  logic               cell_valid [N];
  logic               cell_ready [N];
  rhc_pkg::rhc_cell_t cell_data  [N];

  logic               out_valid_q;
  logic [rhc_pkg::HueW-1:0]  hue_q, hue_d;
  logic [rhc_pkg::ChanW-1:0] sat_q, sat_d, val_q;
  logic               last_ready;

  // Extremes, sector and dividends
  rhc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .red_i       (s_axis_tdata[7:0]),
    .green_i     (s_axis_tdata[15:8]),
    .blue_i      (s_axis_tdata[23:16]),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_o       (front_data)
  );

  // Row of division cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      rhc_div_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .in_valid_i  (front_valid),
        .in_ready_o  (front_ready),
        .in_i        (front_data),
        .out_valid_o (cell_valid[i]),
        .out_ready_i (cell_ready[i]),
        .out_o       (cell_data[i])
      );
    end else begin : g_next
      rhc_div_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .in_valid_i  (cell_valid[i-1]),
        .in_ready_o  (cell_ready[i-1]),
        .in_i        (cell_data[i-1]),
        .out_valid_o (cell_valid[i]),
        .out_ready_i (cell_ready[i]),
        .out_o       (cell_data[i])
      );
    end
  end

  assign last_ready   = !out_valid_q || m_axis_tready;
  assign cell_ready[N-1] = last_ready;

  // Apply sector base, floor correction for negative offsets, and grey case
  always_comb begin
    logic [rhc_pkg::HueW-1:0] q;
    logic [rhc_pkg::HueW-1:0] top;
    logic                     inexact;
    q       = rhc_pkg::HueW'(cell_data[N-1].hue_lane.nq);
    inexact = (cell_data[N-1].hue_lane.rem != '0);
    top     = cell_data[N-1].red_max ? rhc_pkg::HueTurn : cell_data[N-1].base;
    if (cell_data[N-1].grey) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      if (cell_data[N-1].neg) begin
        hue_d = top - q - rhc_pkg::HueW'(inexact);
      end else begin
        hue_d = cell_data[N-1].base + q;
      end
      sat_d = cell_data[N-1].sat_lane.nq[rhc_pkg::ChanW-1:0];
    end
  end

  // Output register: hold while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last_ready) begin
      out_valid_q <= cell_valid[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_ready && cell_valid[N-1]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= cell_data[N-1].val;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, val_q, sat_q, hue_q};

  // Hue stays below a full turn
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (hue_q < rhc_pkg::HueTurn))
    else $error("hue out of range");

  // Zero saturation only for grey pixels, whose hue is zero
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (sat_q == '0)) |-> (hue_q == '0))
    else $error("zero saturation with nonzero hue");

  // Empty output register lets the whole row accept
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

`default_nettype wire

// ===== hw/rtl/rhc_front.sv =====
`default_nettype none

module rhc_front (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  [rhc_pkg::ChanW-1:0]     red_i,
  input  wire  [rhc_pkg::ChanW-1:0]     green_i,
  input  wire  [rhc_pkg::ChanW-1:0]     blue_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output rhc_pkg::rhc_cell_t            out_o
);

  logic                      valid_q;
  rhc_pkg::rhc_cell_t        data_q, data_d;

  logic [rhc_pkg::ChanW-1:0] mx, mn, delta, op_a, op_b, mag;
  logic                      red_max, green_max, neg;
  logic [rhc_pkg::HueDivW-1:0] hue_dvd;
  logic [2*rhc_pkg::ChanW-1:0] sat_dvd;

  // Find extremes and pick the sector, red winning ties before green
  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;

    red_max   = (mx == red_i);
    green_max = !red_max && (mx == green_i);

    if (red_max) begin
      op_a = green_i;
      op_b = blue_i;
    end else if (green_max) begin
      op_a = blue_i;
      op_b = red_i;
    end else begin
      op_a = red_i;
      op_b = green_i;
    end
    neg = (op_a < op_b);
    mag = neg ? (op_b - op_a) : (op_a - op_b);

    hue_dvd = rhc_pkg::HueDivW'(mag) * rhc_pkg::HueDivW'(rhc_pkg::HueMul);
    sat_dvd = (2*rhc_pkg::ChanW)'(delta) * (2*rhc_pkg::ChanW)'(rhc_pkg::SatMul);

    data_d.hue_lane.rem = hue_dvd[rhc_pkg::HueDivW-1 -: rhc_pkg::ChanW];
    data_d.hue_lane.dvs = delta;
    data_d.hue_lane.nq  = hue_dvd[rhc_pkg::QuoW-1:0];
    data_d.sat_lane.rem = rhc_pkg::ChanW'(sat_dvd[2*rhc_pkg::ChanW-1:rhc_pkg::QuoW]);
    data_d.sat_lane.dvs = mx;
    data_d.sat_lane.nq  = sat_dvd[rhc_pkg::QuoW-1:0];
    data_d.base    = red_max ? '0 : (green_max ? rhc_pkg::HueGreen : rhc_pkg::HueBlue);
    data_d.red_max = red_max;
    data_d.neg     = neg;
    data_d.grey    = (delta == '0);
    data_d.val     = mx;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // Hold or advance the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rhc_div_cell.sv =====
`default_nettype none

module rhc_div_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire rhc_pkg::rhc_cell_t in_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output rhc_pkg::rhc_cell_t   out_o
);

  logic               valid_q;
  rhc_pkg::rhc_cell_t data_q, data_d;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  function automatic rhc_pkg::rhc_lane_t div_step(input rhc_pkg::rhc_lane_t l);
    logic [rhc_pkg::ChanW:0] trial;
    logic                    fit;
    rhc_pkg::rhc_lane_t      res;
    trial   = {l.rem, l.nq[rhc_pkg::QuoW-1]};
    fit     = (trial >= {1'b0, l.dvs});
    res.dvs = l.dvs;
    res.rem = fit ? rhc_pkg::ChanW'(trial - {1'b0, l.dvs}) : trial[rhc_pkg::ChanW-1:0];
    res.nq  = {l.nq[rhc_pkg::QuoW-2:0], fit};
    return res;
  endfunction

  always_comb begin
    data_d          = in_i;
    data_d.hue_lane = div_step(in_i.hue_lane);
    data_d.sat_lane = div_step(in_i.sat_lane);
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // Hold or advance the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

`default_nettype wire
